[design/mbpd_pkg.sv]
// Package with the constants, codes and item types of the magic byte packet deframer.
package mbpd_pkg;

	localparam logic [7:0] SYNC_BYTE       = 8'hAA;
	localparam logic [7:0] ACK_CODE        = 8'h06;
	localparam logic [7:0] CMD_FIRST_QUERY = 8'h01;
	localparam logic [7:0] CMD_LAST_QUERY  = 8'h03;
	localparam logic [7:0] CMD_SET_DEBUG   = 8'h04;
	localparam logic [7:0] CMD_CLR_DEBUG   = 8'h05;

	localparam int unsigned ACK_LEN = 5;

	localparam logic KIND_RETURN = 1'b0;
	localparam logic KIND_ACK    = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		HDR_CMD      = 2'd0,
		HDR_LEN_LO   = 2'd1,
		HDR_LEN_HI   = 2'd2,
		HDR_CHECKSUM = 2'd3
	} hdr_idx_t;

	typedef logic [2:0] pend_t;

	localparam pend_t PEND_NONE      = 3'd0;
	localparam pend_t PEND_SINGLE    = 3'd1;
	localparam pend_t PEND_ACK_BURST = 3'(ACK_LEN + 1);

	typedef struct packed {
		logic [7:0] rx_byte;
	} rx_item_t;

	typedef struct packed {
		logic       item_kind;
		logic [7:0] tx_byte;
		logic [2:0] return_code;
		logic       debug_on;
		logic       last;
	} tx_item_t;

	// The acknowledge frame is sent while the pending count runs down from a full burst.
	function automatic logic [7:0] ack_byte(input pend_t pend);
		logic [7:0] b;
		case (pend)
			PEND_ACK_BURST:         b = SYNC_BYTE;
			PEND_ACK_BURST - 3'd1:  b = ACK_CODE;
			default:                b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

[design/mbpd_stream_if.sv]
// Valid/ready stream interface carrying one payload item per transfer.
interface mbpd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[design/magic_byte_packet_deframer.sv]
// Top level of the magic byte packet deframer: header parser, result sequencer and output register.
//
// The rx channel takes one received byte per transfer. The block hunts for the sync byte,
// reads the command, a little-endian 16-bit length and a checksum byte, then skips the
// payload. The res channel delivers the result items of a completed packet: for the set
// and clear debug commands five acknowledge bytes followed by the return item, otherwise
// the return item alone. The item with last set closes each packet's results.
// Bytes that cause no result are taken at one per cycle. The completing byte loads a
// pending count, and the result items then enter the output register one per cycle while
// it is free or being emptied. The rx side is held off until the last pending item moves
// into the output register, so with a free output register a packet with an acknowledge
// holds it off while its acknowledge bytes move in and any other packet does not hold it
// off. The rx side is open again while the last result still waits in the output
// register. When the receiver stalls, the output register holds its item and the pending
// count stops, which holds off the rx side once a packet completes. Reset returns the
// parser to sync hunting, clears the debug flag and empties the output register.
module magic_byte_packet_deframer (
	input logic          clk,
	input logic          arst_n,
	mbpd_stream_if.sink   rx,
	mbpd_stream_if.source res
);
	import mbpd_pkg::*;

	phase_t      phase_q, phase_d;
	hdr_idx_t    hdr_q, hdr_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [15:0] len_q, len_d;
	logic [15:0] cnt_q, cnt_d;
	logic [15:0] cnt_inc;
	logic        debug_q, debug_d;
	pend_t       pend_q, pend_d;
	logic        out_valid_q;
	tx_item_t    out_q;
	tx_item_t    item;
	logic        rx_fire;
	logic        dispatch;
	logic        is_ack_cmd;
	logic        out_load;
	logic [7:0]  b;
	logic [2:0]  ret_code;

	assign b          = rx.payload.rx_byte;
	assign rx.ready   = (pend_q == PEND_NONE) || ((pend_q == PEND_SINGLE) && out_load);
	assign rx_fire    = rx.valid && rx.ready;
	assign is_ack_cmd = (cmd_q == CMD_SET_DEBUG) || (cmd_q == CMD_CLR_DEBUG);
	assign out_load   = (pend_q != PEND_NONE) && (!out_valid_q || res.ready);
	assign cnt_inc    = cnt_q + 16'd1;

	always_comb begin
		phase_d  = phase_q;
		hdr_d    = hdr_q;
		cmd_d    = cmd_q;
		len_d    = len_q;
		cnt_d    = cnt_q;
		debug_d  = debug_q;
		dispatch = 1'b0;
		if (rx_fire) begin
			case (phase_q)
				PH_HEADER: begin
					case (hdr_q)
						HDR_CMD: begin
							cmd_d = b;
							hdr_d = HDR_LEN_LO;
						end
						HDR_LEN_LO: begin
							len_d = {len_q[15:8], b};
							hdr_d = HDR_LEN_HI;
						end
						HDR_LEN_HI: begin
							len_d = {b, len_q[7:0]};
							hdr_d = HDR_CHECKSUM;
						end
						HDR_CHECKSUM: begin
							hdr_d = HDR_CMD;
							cnt_d = 16'd0;
							if (len_q == 16'd0) begin
								dispatch = 1'b1;
								phase_d  = PH_IDLE;
							end else begin
								phase_d = PH_PAYLOAD;
							end
						end
						default: hdr_d = HDR_CMD;
					endcase
				end
				PH_PAYLOAD: begin
					cnt_d = cnt_inc;
					if (cnt_inc >= len_q) begin
						dispatch = 1'b1;
						phase_d  = PH_IDLE;
					end
				end
				default: begin
					if (b == SYNC_BYTE) begin
						phase_d = PH_HEADER;
						hdr_d   = HDR_CMD;
					end else begin
						phase_d = PH_IDLE;
					end
				end
			endcase
		end
		if (dispatch) begin
			if (cmd_q == CMD_SET_DEBUG) begin
				debug_d = 1'b1;
			end else if (cmd_q == CMD_CLR_DEBUG) begin
				debug_d = 1'b0;
			end
		end
		if (dispatch) begin
			pend_d = is_ack_cmd ? PEND_ACK_BURST : PEND_SINGLE;
		end else if (out_load) begin
			pend_d = pend_q - PEND_SINGLE;
		end else begin
			pend_d = pend_q;
		end
	end

	always_comb begin
		if (cmd_q inside {[CMD_FIRST_QUERY:CMD_LAST_QUERY]}) begin
			ret_code = debug_q ? cmd_q[2:0] : 3'd0;
		end else if (is_ack_cmd) begin
			ret_code = cmd_q[2:0];
		end else begin
			ret_code = 3'd0;
		end
		item.debug_on = debug_q;
		if (is_ack_cmd && (pend_q != PEND_SINGLE)) begin
			item.item_kind   = KIND_ACK;
			item.tx_byte     = ack_byte(pend_q);
			item.return_code = 3'd0;
			item.last        = 1'b0;
		end else begin
			item.item_kind   = KIND_RETURN;
			item.tx_byte     = 8'h00;
			item.return_code = ret_code;
			item.last        = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			hdr_q       <= HDR_CMD;
			cmd_q       <= 8'h00;
			len_q       <= 16'd0;
			cnt_q       <= 16'd0;
			debug_q     <= 1'b0;
			pend_q      <= PEND_NONE;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			hdr_q   <= hdr_d;
			cmd_q   <= cmd_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			debug_q <= debug_d;
			pend_q  <= pend_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= item;
		end
	end

	assign res.valid   = out_valid_q;
	assign res.payload = out_q;

	a_ack_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.item_kind == KIND_ACK) |-> !out_q.last)
		else $error("Acknowledge byte marked as last item.");

	a_set_debug_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.item_kind == KIND_RETURN && out_q.return_code == 3'd4)
		|-> out_q.debug_on)
		else $error("Set debug return item without debug on.");

	a_clr_debug_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.item_kind == KIND_RETURN && out_q.return_code == 3'd5)
		|-> !out_q.debug_on)
		else $error("Clear debug return item with debug on.");

	a_query_needs_debug: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.return_code == 3'd1 || out_q.return_code == 3'd2
		|| out_q.return_code == 3'd3)) |-> out_q.debug_on)
		else $error("Query answered while debug is off.");

endmodule

[test/magic_byte_packet_deframer_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the magic byte packet deframer: directed and random framing with stalls.
module magic_byte_packet_deframer_test;
	import mbpd_pkg::*;

	localparam int unsigned CYCLE_LIMIT     = 500000;
	localparam int unsigned RANDOM_BYTES    = 460;
	localparam int unsigned CALM_BYTES      = 400;
	localparam int unsigned HOLD_OFF_CYCLES = 300;
	localparam int unsigned SETTLE_CYCLES   = 20;

	class reply_scoreboard;
		phase_t      phase;
		hdr_idx_t    hdr_pos;
		logic [7:0]  command;
		logic [15:0] length;
		logic [15:0] taken;
		logic        debug;
		tx_item_t    awaited_replies[$];
		int unsigned failures;

		function new();
			phase = PH_IDLE;
			hdr_pos = HDR_CMD;
			command = '0;
			length = '0;
			taken = '0;
			debug = 1'b0;
			failures = 0;
		endfunction

		function void push_reply(logic kind, logic [7:0] tx, logic [2:0] code, logic fin);
			tx_item_t r;
			r.item_kind = kind;
			r.tx_byte = tx;
			r.return_code = code;
			r.debug_on = debug;
			r.last = fin;
			awaited_replies.push_back(r);
		endfunction

		function void finish_packet();
			logic [2:0] code;
			code = '0;
			if (command >= CMD_FIRST_QUERY && command <= CMD_LAST_QUERY) begin
				if (debug)
					code = command[2:0];
			end else if (command == CMD_SET_DEBUG || command == CMD_CLR_DEBUG) begin
				debug = (command == CMD_SET_DEBUG);
				for (int i = 0; i < ACK_LEN; i++)
					push_reply(KIND_ACK, (i == 0) ? SYNC_BYTE : (i == 1) ? ACK_CODE : 8'h00,
						3'd0, 1'b0);
				code = command[2:0];
			end
			push_reply(KIND_RETURN, 8'h00, code, 1'b1);
			phase = PH_IDLE;
		endfunction

		function void take_rx_byte(logic [7:0] b);
			case (phase)
				PH_HEADER: begin
					case (hdr_pos)
						HDR_CMD: begin
							command = b;
							hdr_pos = HDR_LEN_LO;
						end
						HDR_LEN_LO: begin
							length[7:0] = b;
							hdr_pos = HDR_LEN_HI;
						end
						HDR_LEN_HI: begin
							length[15:8] = b;
							hdr_pos = HDR_CHECKSUM;
						end
						default: begin
							hdr_pos = HDR_CMD;
							taken = '0;
							if (length == 16'd0)
								finish_packet();
							else
								phase = PH_PAYLOAD;
						end
					endcase
				end
				PH_PAYLOAD: begin
					taken++;
					if (taken >= length)
						finish_packet();
				end
				default: begin
					phase = (b == SYNC_BYTE) ? PH_HEADER : PH_IDLE;
					hdr_pos = HDR_CMD;
				end
			endcase
		endfunction

		function void report(string field, logic [7:0] want, logic [7:0] got);
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			failures++;
		endfunction

		function void check_reply(tx_item_t got);
			tx_item_t want;
			if (awaited_replies.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %p", $time, got);
				failures++;
			end else begin
				want = awaited_replies.pop_front();
				if (got.item_kind !== want.item_kind)
					report("item_kind", 8'(want.item_kind), 8'(got.item_kind));
				if (got.tx_byte !== want.tx_byte)
					report("tx_byte", want.tx_byte, got.tx_byte);
				if (got.return_code !== want.return_code)
					report("return_code", 8'(want.return_code), 8'(got.return_code));
				if (got.debug_on !== want.debug_on)
					report("debug_on", 8'(want.debug_on), 8'(got.debug_on));
				if (got.last !== want.last)
					report("last", 8'(want.last), 8'(got.last));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	mbpd_stream_if #(.payload_t(rx_item_t)) rx_if ();
	mbpd_stream_if #(.payload_t(tx_item_t)) res_if ();

	magic_byte_packet_deframer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_if.sink),
		.res(res_if.source)
	);

	reply_scoreboard board = new();
	bit calm = 1'b0;
	bit hold_off_request = 1'b0;
	int unsigned gap_odds = 0;
	int unsigned cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			board.check_reply(res_if.payload);
	end

	initial begin
		res_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_request) begin
				res_if.ready <= 1'b0;
				hold_off_request = 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(3) == 0) begin
				res_if.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				res_if.ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	task automatic send_byte(logic [7:0] b);
		if (!calm && gap_odds != 0 && $urandom_range(gap_odds) == 0) begin
			rx_if.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.payload <= b;
		@(posedge clk);
		while (!rx_if.ready)
			@(posedge clk);
		board.take_rx_byte(b);
	endtask

	task automatic send_packet(logic [7:0] cmd, logic [15:0] len);
		send_byte(SYNC_BYTE);
		send_byte(cmd);
		send_byte(len[7:0]);
		send_byte(len[15:8]);
		send_byte(8'($urandom_range(255)));
		repeat (len)
			send_byte(8'($urandom_range(255)));
	endtask

	initial begin
		int unsigned sent;
		int unsigned pick;
		logic [7:0] cmd;
		logic [15:0] len;
		bit longest_done;
		arst_n <= 1'b0;
		rx_if.valid <= 1'b0;
		rx_if.payload <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_odds = 3;
		send_byte(8'h00);
		send_byte(8'hFF);
		send_packet(CMD_FIRST_QUERY, 16'h0000);
		send_packet(CMD_SET_DEBUG, 16'h0001);
		send_packet(CMD_FIRST_QUERY + 8'd1, 16'h0000);
		send_packet(CMD_LAST_QUERY, 16'h0000);
		send_packet(CMD_CLR_DEBUG, 16'h0000);
		send_packet(8'hFF, 16'h0000);

		// The receiver holds off for a long stretch while packets keep coming.
		hold_off_request = 1'b1;
		sent = 0;
		longest_done = 1'b0;
		while (sent < RANDOM_BYTES) begin
			calm = (sent >= CALM_BYTES);
			gap_odds = $urandom_range(0, 5);
			if ($urandom_range(5) == 0) begin
				pick = $urandom_range(1, 3);
				repeat (pick)
					send_byte(8'($urandom_range(255)));
				sent += pick;
			end
			if ($urandom_range(4) == 0)
				cmd = 8'($urandom_range(255));
			else
				cmd = 8'($urandom_range(CMD_FIRST_QUERY, CMD_CLR_DEBUG));
			pick = $urandom_range(49);
			if (pick == 0)
				len = 16'($urandom_range(256, 511));
			else if (pick < 3)
				len = 16'($urandom_range(255));
			else
				len = 16'($urandom_range(4));
			if (!longest_done && sent >= RANDOM_BYTES / 2) begin
				gap_odds = 0;
				len = 16'h0100;
				longest_done = 1'b1;
			end
			send_packet(cmd, len);
			sent += 5 + len;
		end
		rx_if.valid <= 1'b0;

		while (board.awaited_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
